@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/atpd_pkg.sv @@
package atpd_pkg;

	// Sample width default and fixed field widths
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int INDEX_BITS      = 32;
	localparam int FACTOR_BITS     = 16;
	localparam int ALPHA_BITS      = 17;

	// Configuration port geometry
	localparam int ADDR_BITS = 4;
	localparam int DATA_BITS = 32;

	// Register reset values
	localparam logic [FACTOR_BITS-1:0] RISE_RESET  = 16'd1024;
	localparam logic [FACTOR_BITS-1:0] FALL_RESET  = 16'd1638;
	localparam logic [ALPHA_BITS-1:0]  ALPHA_RESET = 17'd66;

	// Register indexes (byte address / 4)
	typedef enum logic [1:0] {
		REG_RISE  = 2'd0,
		REG_FALL  = 2'd1,
		REG_ALPHA = 2'd2
	} reg_idx_t;

	// Threshold test results for one sample
	typedef struct packed {
		logic above_rise;
		logic above_fall;
	} thresh_t;

endpackage

@@ rtl/atpd_thresh.sv @@
module atpd_thresh #(
	parameter int SAMPLE_BITS = atpd_pkg::SAMPLE_BITS_DEF
) (
	input  logic signed [SAMPLE_BITS-1:0]    sample,
	input  logic signed [SAMPLE_BITS+15:0]   avg,
	input  logic [atpd_pkg::FACTOR_BITS-1:0] rise_factor,
	input  logic [atpd_pkg::FACTOR_BITS-1:0] fall_factor,
	output atpd_pkg::thresh_t                thresh
);
	import atpd_pkg::*;

	logic signed [SAMPLE_BITS+27:0] lhs;
	logic signed [SAMPLE_BITS+32:0] rise_m;
	logic signed [SAMPLE_BITS+32:0] fall_m;

	// Exact compare: sample * 2^28 against average (Q.16) times factor (Q4.12)
	assign lhs    = $signed({sample, 28'd0});
	assign rise_m = avg * $signed({1'b0, rise_factor});
	assign fall_m = avg * $signed({1'b0, fall_factor});

	assign thresh.above_rise = lhs > rise_m;
	assign thresh.above_fall = lhs > fall_m;

endmodule

@@ rtl/atpd_ema.sv @@
module atpd_ema #(
	parameter int SAMPLE_BITS = atpd_pkg::SAMPLE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            upd,
	input  logic signed [SAMPLE_BITS-1:0]   sample,
	input  logic [atpd_pkg::ALPHA_BITS-1:0] avg_alpha,
	output logic signed [SAMPLE_BITS+15:0]  avg
);
	import atpd_pkg::*;

	localparam int AW = SAMPLE_BITS + 16;
	localparam int SW = SAMPLE_BITS + 19;

	logic [ALPHA_BITS-1:0]          a_eff;
	logic [ALPHA_BITS-1:0]          a_inv;
	logic signed [SAMPLE_BITS+17:0] prod_x;
	logic signed [SAMPLE_BITS+33:0] prod_avg;
	logic signed [SW-1:0]           sum;
	logic                           ovf;
	logic signed [AW-1:0]           avg_next;
	logic signed [AW-1:0]           avg_q;

	// Limit alpha to one, then weight sample and old average
	assign a_eff    = avg_alpha[ALPHA_BITS-1] ? {1'b1, {(ALPHA_BITS-1){1'b0}}} : avg_alpha;
	assign a_inv    = {1'b1, {(ALPHA_BITS-1){1'b0}}} - a_eff;
	assign prod_x   = $signed({1'b0, a_eff}) * sample;
	assign prod_avg = $signed({1'b0, a_inv}) * avg_q;

	// Arithmetic shift floors toward minus infinity
	assign sum = SW'(prod_x) + SW'($signed(prod_avg[SAMPLE_BITS+33:16]));

	// Saturate to the sample range in Q.16
	assign ovf = !(&sum[SW-1:AW-1]) && (|sum[SW-1:AW-1]);

	always_comb begin
		if (ovf) begin
			avg_next = sum[SW-1] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
		end else begin
			avg_next = sum[AW-1:0];
		end
	end

	// Hold average, fold in each processed sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_q <= '0;
		end else if (upd) begin
			avg_q <= avg_next;
		end
	end

	assign avg = avg_q;

endmodule

@@ rtl/adaptive_threshold_peak_detector.sv @@
// A sample that ends a peak loads its result into the output register when it advances.
// Throughput: one sample per cycle unless the input register stalls; the average updates in place.
// The input register stalls only when a result must be loaded while the output one is full
// and not drained in that cycle.
// Reset (arst_n low): idle mode, average and sample count zero, output empty,
// registers back to rise 1024, fall 1638, alpha 66.
`include "assert_macros.svh"

module adaptive_threshold_peak_detector #(
	parameter int SAMPLE_BITS = atpd_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	// tdata: sample
	input  logic                                    s_tvalid,
	output logic                                    s_tready,
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]        s_tdata,
	// tdata: peak_index [31:0], peak_value above it
	output logic                                    m_tvalid,
	input  logic                                    m_tready,
	output logic [((SAMPLE_BITS+39)/8)*8-1:0]       m_tdata,
	input  logic                                    psel,
	input  logic                                    penable,
	input  logic                                    pwrite,
	input  logic [atpd_pkg::ADDR_BITS-1:0]          paddr,
	input  logic [atpd_pkg::DATA_BITS-1:0]          pwdata,
	output logic [atpd_pkg::DATA_BITS-1:0]          prdata,
	output logic                                    pready
);
	import atpd_pkg::*;

	localparam int AW     = SAMPLE_BITS + 16;
	localparam int OUT_TW = ((SAMPLE_BITS + 39) / 8) * 8;

	logic [FACTOR_BITS-1:0]        rise_q;
	logic [FACTOR_BITS-1:0]        fall_q;
	logic [ALPHA_BITS-1:0]         alpha_q;
	reg_idx_t                      reg_idx;

	logic                          valid_s1;
	logic signed [SAMPLE_BITS-1:0] sample_s1;

	logic                          tracking_q;
	logic signed [SAMPLE_BITS-1:0] best_value_q;
	logic [INDEX_BITS-1:0]         best_index_q;
	logic [INDEX_BITS-1:0]         count_q;

	logic                          out_valid_q;
	logic [INDEX_BITS-1:0]         out_index_q;
	logic signed [SAMPLE_BITS-1:0] out_value_q;

	logic signed [AW-1:0]          avg;
	thresh_t                       thresh;
	logic                          new_max;
	logic                          emit;
	logic                          adv;
	logic                          start_peak;

	// Configuration port
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rise_q  <= RISE_RESET;
			fall_q  <= FALL_RESET;
			alpha_q <= ALPHA_RESET;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_idx)
				REG_RISE:  rise_q  <= pwdata[FACTOR_BITS-1:0];
				REG_FALL:  fall_q  <= pwdata[FACTOR_BITS-1:0];
				REG_ALPHA: alpha_q <= pwdata[ALPHA_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_RISE:  prdata = DATA_BITS'(rise_q);
			REG_FALL:  prdata = DATA_BITS'(fall_q);
			REG_ALPHA: prdata = DATA_BITS'(alpha_q);
			default:   prdata = '0;
		endcase
	end

	// Threshold tests and running average
	atpd_thresh #(.SAMPLE_BITS(SAMPLE_BITS)) u_thresh (
		.sample      (sample_s1),
		.avg         (avg),
		.rise_factor (rise_q),
		.fall_factor (fall_q),
		.thresh      (thresh)
	);

	atpd_ema #(.SAMPLE_BITS(SAMPLE_BITS)) u_ema (
		.clk       (clk),
		.arst_n    (arst_n),
		.upd       (adv),
		.sample    (sample_s1),
		.avg_alpha (alpha_q),
		.avg       (avg)
	);

	// Decide: extend peak, end it (result), or start a new one
	assign new_max    = tracking_q && (sample_s1 > best_value_q);
	assign emit       = tracking_q && !new_max && !thresh.above_fall;
	assign start_peak = (!tracking_q || emit) && thresh.above_rise;

	// Advance unless a result would overrun a full output register
	assign adv      = valid_s1 && (!emit || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			sample_s1 <= $signed(s_tdata[SAMPLE_BITS-1:0]);
		end
	end

	// Peak tracking state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tracking_q <= 1'b0;
			count_q    <= '0;
		end else if (adv) begin
			tracking_q <= (tracking_q && !emit) || start_peak;
			count_q    <= count_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && (new_max || start_peak)) begin
			best_value_q <= sample_s1;
			best_index_q <= count_q;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			out_index_q <= best_index_q;
			out_value_q <= best_value_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_TW'({out_value_q, out_index_q});

	// Checks
	`ASSERT_NEXT(a_emit_loads, clk, arst_n, adv && emit, m_tvalid && (m_tdata[INDEX_BITS-1:0] == $past(best_index_q)))
	`ASSERT_NEXT(a_count_step, clk, arst_n, adv, count_q == $past(count_q) + 32'd1)
	`ASSERT_IMPLIES(a_track_end, clk, arst_n, $fell(tracking_q), $past(adv && emit))

endmodule
